@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent assertions used by the parser checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define MCP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, during reset as well.
`define MCP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/mcp_pkg.sv @@
// ---------------------------------------------------------------------------
// MIDI channel message parser package
// Shared types and constants of the parser front end, queue and back end.
// ---------------------------------------------------------------------------
package mcp_pkg;

  // Depth of the message queue between the front and back ends.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Filter value that lets every channel through.
  localparam logic [4:0] AllChannels = 5'd16;

  // Upper nibble of a status byte.
  localparam logic [3:0] TypeNoteOff  = 4'h8;
  localparam logic [3:0] TypeNoteOn   = 4'h9;
  localparam logic [3:0] TypeControl  = 4'hB;
  localparam logic [3:0] TypeProgram  = 4'hC;
  localparam logic [3:0] TypePressure = 4'hD;

  typedef enum logic [1:0] {
    KIND_NOTE_OFF = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_CONTROL  = 2'd2,
    KIND_PROGRAM  = 2'd3
  } event_kind_e;

  // One completed channel message as parsed from the byte stream.
  typedef struct packed {
    logic [3:0] msg_type;
    logic [3:0] channel;
    logic [6:0] first_value;
    logic [6:0] second_value;
  } msg_t;

endpackage

@@ rtl/core/mcp_front.sv @@
// ---------------------------------------------------------------------------
// MIDI parser front end
// Tracks running status and data count, and emits each completed message.
// ---------------------------------------------------------------------------
module mcp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          byte_valid_i,
  input  logic [7:0]    rx_byte_i,
  output logic          msg_valid_o,
  output mcp_pkg::msg_t msg_o
);
  import mcp_pkg::*;

  logic [7:0] running_status_q, running_status_d;
  logic       data_count_q, data_count_d;
  logic [6:0] held_first_q;
  logic       held_load;
  logic       one_byte_msg;

  // Program change and channel pressure carry a single data byte.
  assign one_byte_msg = (running_status_q[7:4] == TypeProgram) ||
                        (running_status_q[7:4] == TypePressure);

  always_comb begin
    running_status_d = running_status_q;
    data_count_d     = data_count_q;
    held_load        = 1'b0;
    msg_valid_o      = 1'b0;
    msg_o.msg_type     = running_status_q[7:4];
    msg_o.channel      = running_status_q[3:0];
    msg_o.first_value  = data_count_q ? held_first_q : rx_byte_i[6:0];
    msg_o.second_value = data_count_q ? rx_byte_i[6:0] : 7'd0;
    if (byte_valid_i) begin
      if (rx_byte_i[7]) begin
        running_status_d = rx_byte_i;
        data_count_d     = 1'b0;
      end else if (running_status_q != 8'd0) begin
        if (!data_count_q && !one_byte_msg) begin
          held_load    = 1'b1;
          data_count_d = 1'b1;
        end else begin
          msg_valid_o  = 1'b1;
          data_count_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_status_q <= 8'd0;
      data_count_q     <= 1'b0;
    end else begin
      running_status_q <= running_status_d;
      data_count_q     <= data_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (held_load) begin
      held_first_q <= rx_byte_i[6:0];
    end
  end

endmodule

@@ rtl/core/mcp_queue.sv @@
// ---------------------------------------------------------------------------
// MIDI parser message queue
// Small first-in first-out buffer of parsed messages.
// ---------------------------------------------------------------------------
module mcp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mcp_pkg::msg_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mcp_pkg::msg_t data_o
);
  import mcp_pkg::*;

  localparam logic [QPtrW-1:0] LastPtr  = QPtrW'(QueueDepth - 1);
  localparam logic [QCntW-1:0] FullCnt  = QCntW'(QueueDepth);

  msg_t             entry_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/core/mcp_back.sv @@
// ---------------------------------------------------------------------------
// MIDI parser back end
// Filters messages by channel, maps them to events and holds the result.
// ---------------------------------------------------------------------------
module mcp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [4:0]           cfg_data_i,
  input  logic                 msg_empty_i,
  input  mcp_pkg::msg_t        msg_i,
  output logic                 msg_pop_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output mcp_pkg::event_kind_e kind_o,
  output logic [3:0]           channel_o,
  output logic [6:0]           first_o,
  output logic [6:0]           second_o
);
  import mcp_pkg::*;

  logic [4:0]  listen_q;
  logic        out_valid_q, out_valid_d;
  event_kind_e kind_q, kind_d;
  logic [3:0]  channel_q;
  logic [6:0]  first_q;
  logic [6:0]  second_q, second_d;
  logic        is_event;
  logic        chan_pass;
  logic        take;
  logic        emit;

  // Decode the message type into an event kind; other types are dropped.
  always_comb begin
    is_event = 1'b1;
    kind_d   = KIND_NOTE_OFF;
    second_d = msg_i.second_value;
    unique case (msg_i.msg_type)
      TypeNoteOff: kind_d = KIND_NOTE_OFF;
      TypeNoteOn:  kind_d = (msg_i.second_value != 7'd0) ? KIND_NOTE_ON : KIND_NOTE_OFF;
      TypeControl: kind_d = KIND_CONTROL;
      TypeProgram: begin
        kind_d   = KIND_PROGRAM;
        second_d = 7'd0;
      end
      default:     is_event = 1'b0;
    endcase
  end

  assign chan_pass = (listen_q == AllChannels) || ({1'b0, msg_i.channel} == listen_q);
  assign take      = !msg_empty_i && (!out_valid_q || pop_i);
  assign emit      = take && is_event && chan_pass;
  assign msg_pop_o = take;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_q    <= AllChannels;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        listen_q <= cfg_data_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q    <= kind_d;
      channel_q <= msg_i.channel;
      first_q   <= msg_i.first_value;
      second_q  <= second_d;
    end
  end

  assign empty_o   = !out_valid_q;
  assign kind_o    = kind_q;
  assign channel_o = channel_q;
  assign first_o   = first_q;
  assign second_o  = second_q;

endmodule

@@ rtl/core/midi_channel_message_parser.sv @@
// ---------------------------------------------------------------------------
// MIDI channel message parser
// Turns a stream of received MIDI bytes into note and controller events.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Payload
//   -------   ---------  ----------------------  -------------------------------
//   bytes     in         push / full             rx_byte_i
//   config    in         cfg_valid_i/cfg_ready_o cfg_listen_channel_i
//   events    out        empty / pop             event_kind_o, event_channel_o,
//                                                first_value_o, second_value_o
//
// One byte is taken in every cycle while full is low. A byte that completes a
// message is written into the message queue at its transfer edge, and the back
// end then loads its event into the output register, where it becomes visible,
// once that register is empty or is being popped.
// Reset clears the running status and sets the channel filter to all channels.
// When the result is not popped, the two-entry message queue absorbs further
// completed messages, and full rises only when both entries are taken.
// The configuration channel is always ready.
//
// The front end follows the running status of the byte stream. A status byte
// (bit 7 set) is stored and restarts the data count. Data bytes that arrive
// before any status are ignored. Program change and channel pressure complete
// on their first data byte; every other type holds the first data byte and
// completes on the second. The status is kept after a message so that
// running status works.
//
// The back end drops messages of types that produce no event, and those whose
// channel does not match the filter. A note on with zero velocity is reported
// as a note off.
module midi_channel_message_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Byte input
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  // Channel filter configuration
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [4:0] cfg_listen_channel_i,
  // Event output
  output logic       empty,
  input  logic       pop,
  output logic [1:0] event_kind_o,
  output logic [3:0] event_channel_o,
  output logic [6:0] first_value_o,
  output logic [6:0] second_value_o
);
  import mcp_pkg::*;

  logic        byte_xfer;
  logic        front_valid;
  msg_t        front_msg;
  logic        queue_empty;
  logic        queue_pop;
  msg_t        queue_msg;
  event_kind_e out_kind;

  // The filter register may be written at any time.
  assign cfg_ready_o = 1'b1;

  // A byte transfer happens only while the message queue has room.
  assign byte_xfer = push && !full;

  mcp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_xfer),
    .rx_byte_i    (rx_byte_i),
    .msg_valid_o  (front_valid),
    .msg_o        (front_msg)
  );

  mcp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_msg),
    .full_o  (full),
    .pop_i   (queue_pop),
    .empty_o (queue_empty),
    .data_o  (queue_msg)
  );

  mcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_listen_channel_i),
    .msg_empty_i (queue_empty),
    .msg_i       (queue_msg),
    .msg_pop_o   (queue_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .kind_o      (out_kind),
    .channel_o   (event_channel_o),
    .first_o     (first_value_o),
    .second_o    (second_value_o)
  );

  assign event_kind_o = out_kind;

endmodule

@@ rtl/core/mcp_checker.sv @@
// ---------------------------------------------------------------------------
// MIDI parser checker
// Port-level assertions on the parser, attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mcp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       full,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic [4:0] cfg_listen_channel_i,
  input logic       empty,
  input logic       pop,
  input logic [1:0] event_kind_o,
  input logic [3:0] event_channel_o,
  input logic [6:0] first_value_o,
  input logic [6:0] second_value_o
);
  import mcp_pkg::*;

  logic [4:0]  listen_q;
  logic        chan_match;
  logic        kind_ok;
  logic        stalled;
  logic [19:0] out_bus;

  // Shadow copy of the channel filter, as written through the port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_q <= AllChannels;
    end else if (cfg_valid_i && cfg_ready_o) begin
      listen_q <= cfg_listen_channel_i;
    end
  end

  assign chan_match = (listen_q == AllChannels) || (5'(event_channel_o) == listen_q);
  assign out_bus    = {event_kind_o, event_channel_o, first_value_o, second_value_o};
  assign stalled    = !empty && !pop;
  assign kind_ok    = ((event_kind_o != KIND_NOTE_ON) || (second_value_o != 7'd0)) &&
                      ((event_kind_o != KIND_PROGRAM) || (second_value_o == 7'd0));

  // A waiting result stays put until it is popped.
  `MCP_ASSERT(a_result_held, clk_i, rst_ni, stalled |=> (!empty && $stable(out_bus)), "held result changed")

  // Every event shown passes the configured channel filter.
  `MCP_ASSERT(a_channel_filter, clk_i, rst_ni, !empty |-> chan_match, "event fails the filter")

  // A full queue behind an empty output register gives up one entry at the next edge.
  `MCP_ASSERT(a_full_clears, clk_i, rst_ni, (full && empty) |=> !full, "full queue did not drain")

  // A note on never carries zero velocity, and a program change has no second value.
  `MCP_ASSERT(a_kind_values, clk_i, rst_ni, !empty |-> kind_ok, "event values do not fit its kind")

endmodule

bind midi_channel_message_parser mcp_checker u_checker (.*);

@@ tb/sv/channel_event_tracker_pkg.sv @@
// ---------------------------------------------------------------------------
// Channel event tracker
// Follows the MIDI byte stream accepted by the parser, predicts the channel
// events that it must report and compares them with the events it delivers.
// ---------------------------------------------------------------------------
package channel_event_tracker_pkg;
  import mcp_pkg::*;

  typedef struct packed {
    event_kind_e kind;
    logic [3:0]  channel;
    logic [6:0]  first_value;
    logic [6:0]  second_value;
  } channel_event_t;

  class channel_event_tracker;
    logic [7:0]     running_status;
    logic           waiting_second;
    logic [6:0]     held_first;
    logic [4:0]     listen_channel;
    channel_event_t expected_events[$];
    int unsigned    errors;

    function new();
      running_status = 8'h00;
      waiting_second = 1'b0;
      held_first     = 7'h00;
      listen_channel = AllChannels;
      errors         = 0;
    endfunction

    // Called for every byte transfer into the parser.
    function void parse_byte(logic [7:0] rx);
      channel_event_t ev;
      logic [6:0]     first;
      logic [6:0]     second;
      if (rx[7]) begin
        running_status = rx;
        waiting_second = 1'b0;
        return;
      end
      if (running_status == 8'h00) return;
      if (!waiting_second && running_status[7:4] != TypeProgram &&
          running_status[7:4] != TypePressure) begin
        held_first     = rx[6:0];
        waiting_second = 1'b1;
        return;
      end
      if (waiting_second) begin
        first  = held_first;
        second = rx[6:0];
      end else begin
        first  = rx[6:0];
        second = 7'h00;
      end
      waiting_second = 1'b0;
      case (running_status[7:4])
        TypeNoteOff: ev.kind = KIND_NOTE_OFF;
        TypeNoteOn:  ev.kind = (second != 7'h00) ? KIND_NOTE_ON : KIND_NOTE_OFF;
        TypeControl: ev.kind = KIND_CONTROL;
        TypeProgram: begin
          ev.kind = KIND_PROGRAM;
          second  = 7'h00;
        end
        default: return;
      endcase
      if (listen_channel != AllChannels && listen_channel != {1'b0, running_status[3:0]})
        return;
      ev.channel      = running_status[3:0];
      ev.first_value  = first;
      ev.second_value = second;
      expected_events = {expected_events, ev};
    endfunction

    task report(string msg);
      if (errors < 100) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Called for every event transfer out of the parser.
    task check_event(event_kind_e kind, logic [3:0] channel, logic [6:0] first_value,
                     logic [6:0] second_value);
      channel_event_t want;
      if (expected_events.size() == 0) begin
        report($sformatf("unexpected event %s ch %0d %0d %0d", kind.name(), channel,
                         first_value, second_value));
        return;
      end
      want = expected_events.pop_front();
      if (kind != want.kind)
        report($sformatf("kind %s, expected %s", kind.name(), want.kind.name()));
      if (channel != want.channel)
        report($sformatf("channel %0d, expected %0d", channel, want.channel));
      if (first_value != want.first_value)
        report($sformatf("first value %0d, expected %0d", first_value, want.first_value));
      if (second_value != want.second_value)
        report($sformatf("second value %0d, expected %0d", second_value, want.second_value));
    endtask
  endclass

endpackage

@@ tb/sv/midi_channel_message_parser_test.sv @@
// ---------------------------------------------------------------------------
// MIDI channel message parser test
// Drives byte streams through the parser under several channel filter
// settings and checks every reported event against a predicted event list.
// ---------------------------------------------------------------------------
module midi_channel_message_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mcp_pkg::*;
  import channel_event_tracker_pkg::*;

  // Status nibbles that parse but never produce an event.
  localparam logic [3:0] TypePolyPressure = 4'hA;
  localparam logic [3:0] TypePitchBend    = 4'hE;
  localparam logic [3:0] TypeSystem       = 4'hF;

  // The settle time after each drain covers any message still on its way through
  // the queue and the back end to the filter.
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseBytes   = 245;
  localparam int unsigned StallCycles  = 80;

  logic       clk_i                = 1'b0;
  logic       rst_ni               = 1'b0;
  logic       push                 = 1'b0;
  logic       full;
  logic [7:0] rx_byte_i            = 8'h00;
  logic       cfg_valid_i          = 1'b0;
  logic       cfg_ready_o;
  logic [4:0] cfg_listen_channel_i = 5'd0;
  logic       empty;
  logic       pop                  = 1'b0;
  logic [1:0] event_kind_o;
  logic [3:0] event_channel_o;
  logic [6:0] first_value_o;
  logic [6:0] second_value_o;

  channel_event_tracker tracker = new();

  // Set while both sides run without any idle cycles.
  logic        calm           = 1'b0;
  // The main process bumps this to ask the event side for one long stall.
  int unsigned stall_requests = 0;
  logic [7:0]  last_status    = 8'h00;
  int unsigned bytes_sent     = 0;

  midi_channel_message_parser dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .push                 (push),
    .full                 (full),
    .rx_byte_i            (rx_byte_i),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_listen_channel_i (cfg_listen_channel_i),
    .empty                (empty),
    .pop                  (pop),
    .event_kind_o         (event_kind_o),
    .event_channel_o      (event_channel_o),
    .first_value_o        (first_value_o),
    .second_value_o       (second_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Event side. Outputs are sampled right at the edge, before any update of
  // that edge lands, so a transfer is seen exactly where pop and not empty
  // were both valid. Pop drops at random about a quarter of the time, except
  // in the calm phase and during a requested stall, which holds pop low until
  // its countdown here runs out.
  initial begin
    int unsigned stalls_served;
    int unsigned stall_left;
    stalls_served = 0;
    stall_left    = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty)
        tracker.check_event(event_kind_e'(event_kind_o), event_channel_o, first_value_o,
                            second_value_o);
      if (stalls_served != stall_requests) begin
        stalls_served = stall_requests;
        stall_left    = StallCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= calm || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  // Offers one byte, with random idle cycles in front of it, and returns at
  // the edge where the transfer happens. Push is only lowered while idling,
  // so back to back bytes keep it high without a glitch in the same step.
  task automatic send_byte(input logic [7:0] rx);
    while (!calm && $urandom_range(0, 99) < 24) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    rx_byte_i <= rx;
    do @(posedge clk_i); while (full);
    tracker.parse_byte(rx);
    if (rx[7]) last_status = rx;
    bytes_sent++;
  endtask

  // Stops the byte side until every predicted event has been popped. A
  // missing event keeps this loop waiting until the time limit fires.
  task automatic wait_for_drain();
    push <= 1'b0;
    while (tracker.expected_events.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // The filter is only changed while the parser is drained and idle.
  task automatic write_listen_channel(input logic [4:0] value);
    cfg_valid_i          <= 1'b1;
    cfg_listen_channel_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.listen_channel = value;
  endtask

  // One random message. Most are well formed, often aimed at the listened
  // channel and sometimes relying on running status. About one in ten is a
  // lone random byte and a few are cut short so that the next status byte
  // interrupts them.
  task automatic send_random_message(input logic [4:0] listen);
    int unsigned pick;
    int unsigned data_bytes;
    logic [3:0]  kind_nibble;
    logic [3:0]  channel;
    logic [7:0]  status;
    logic [6:0]  value;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 9))
      0, 1:    kind_nibble = TypeNoteOff;
      2, 3, 4: kind_nibble = TypeNoteOn;
      5, 6:    kind_nibble = TypeControl;
      7, 8:    kind_nibble = TypeProgram;
      default: begin
        case ($urandom_range(0, 3))
          0:       kind_nibble = TypePolyPressure;
          1:       kind_nibble = TypePressure;
          2:       kind_nibble = TypePitchBend;
          default: kind_nibble = TypeSystem;
        endcase
      end
    endcase
    if (listen < AllChannels && $urandom_range(0, 1) == 1) channel = listen[3:0];
    else channel = 4'($urandom_range(0, 15));
    if (last_status[7] && $urandom_range(0, 3) == 0) begin
      status = last_status;
    end else begin
      status = {kind_nibble, channel};
      send_byte(status);
    end
    data_bytes = (status[7:4] == TypeProgram || status[7:4] == TypePressure) ? 1 : 2;
    if (pick < 16) data_bytes--;
    for (int unsigned i = 0; i < data_bytes; i++) begin
      value = 7'($urandom_range(0, 127));
      if ($urandom_range(0, 9) == 0) value = ($urandom_range(0, 1) == 1) ? 7'h7F : 7'h00;
      // A note on with zero velocity has to come out as a note off.
      if (status[7:4] == TypeNoteOn && i == 1 && $urandom_range(0, 5) == 0) value = 7'h00;
      send_byte({1'b0, value});
    end
  endtask

  initial begin
    logic [7:0]  opening_bytes[$];
    logic [4:0]  listen;
    int unsigned phase_end;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Opening stream under the reset filter (all channels). It starts with
    // data bytes that come before any status, then covers each message type,
    // running status on a note on with zero velocity, program change running
    // status, the types that parse without an event, system status bytes
    // that take two data bytes, and a status byte that cuts a message short.
    opening_bytes = '{8'h45, 8'h00,
                      8'h90, 8'h3C, 8'h7F, 8'h3C, 8'h00,
                      8'h8F, 8'h00, 8'h40,
                      8'hB3, 8'h07, 8'h64,
                      8'hC5, 8'h7F, 8'h00,
                      8'hD2, 8'h33,
                      8'hA1, 8'h10, 8'h20,
                      8'hE4, 8'h00, 8'h7F,
                      8'hFF, 8'h12, 8'h34,
                      8'h9A, 8'h22, 8'h91, 8'h30, 8'h31};
    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
    wait_for_drain();

    // Back pressure: the event side stalls for a long stretch while the byte
    // side keeps offering program changes, so the message queue fills up and
    // full has to hold the byte stream off.
    stall_requests++;
    send_byte({TypeProgram, 4'($urandom_range(0, 15))});
    repeat (39) send_byte({1'b0, 7'($urandom_range(0, 127))});
    wait_for_drain();

    // Random phases, each under one filter setting. The plan covers both ends of
    // the channel range, the all-channels value, filter values that match
    // no channel, and one random setting. The third phase runs without idle
    // cycles on either side.
    for (int unsigned phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       listen = 5'd0;
        1:       listen = 5'd15;
        2:       listen = AllChannels;
        3:       listen = 5'd31;
        4:       listen = 5'd17;
        5:       listen = 5'($urandom_range(0, 16));
        default: listen = AllChannels;
      endcase
      write_listen_channel(listen);
      calm      = (phase == 2);
      phase_end = bytes_sent + PhaseBytes;
      while (bytes_sent < phase_end) send_random_message(listen);
      wait_for_drain();
      calm = 1'b0;
    end

    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ midi_channel_message_parser.f @@
+incdir+rtl/core
rtl/core/mcp_pkg.sv
rtl/core/mcp_front.sv
rtl/core/mcp_queue.sv
rtl/core/mcp_back.sv
rtl/core/midi_channel_message_parser.sv
rtl/core/mcp_checker.sv
tb/sv/channel_event_tracker_pkg.sv
tb/sv/midi_channel_message_parser_test.sv
